### rtl/core/tops_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tops_pkg
// shared types, constants and arithmetic helpers of the turn-then-offset
// pose solver
// ----------------------------------------------------------------------------
package tops_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int DIV_QB       = 33;
    localparam int DIV_LAT      = DIV_QB + 2;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic [15:0]        HALF_TURN    = 16'h8000;

    localparam logic [1:0] REG_TURN_RADIUS   = 2'd0;
    localparam logic [1:0] REG_BUMPER_OFFSET = 2'd1;
    localparam logic [1:0] REG_SINE_TOL      = 2'd2;

    localparam logic [30:0] TURN_RADIUS_RST   = 31'd65536;
    localparam logic [30:0] BUMPER_OFFSET_RST = 31'd32768;
    localparam logic [14:0] SINE_TOL_RST      = 15'd1;

    typedef struct packed {
        logic signed [31:0] car_x;
        logic signed [31:0] car_y;
        logic signed [15:0] car_heading;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [15:0] goal_heading;
        logic signed [15:0] bumper_heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] bumper_final_x;
        logic signed [31:0] bumper_final_y;
        logic signed [31:0] robot_final_x;
        logic signed [31:0] robot_final_y;
        logic               used_projection;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat32_t;

    typedef struct packed {
        logic               clip;
        logic signed [32:0] val;
    } sat33_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // floor((v + 2^29) / 2^30)
    function automatic logic signed [34:0] rnd_q30(input logic signed [64:0] v);
        logic signed [64:0] s;
        s = (v + 65'sd536870912) >>> 30;
        return s[34:0];
    endfunction

    function automatic sat32_t sat32(input logic signed [35:0] v);
        sat32_t r;
        r.clip = 1'b0;
        r.val  = v[31:0];
        if (v > 36'sd2147483647)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end
        else if (v < -36'sd2147483648)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        return r;
    endfunction

    function automatic sat33_t sat33(input logic signed [34:0] v);
        sat33_t r;
        r.clip = 1'b0;
        r.val  = v[32:0];
        if (v > 35'sd4294967295)
        begin
            r.clip = 1'b1;
            r.val  = 33'sh0FFFFFFFF;
        end
        else if (v < -35'sd4294967296)
        begin
            r.clip = 1'b1;
            r.val  = 33'sh100000000;
        end
        return r;
    endfunction

endpackage

### rtl/core/turn_then_offset_pose_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_then_offset_pose_solver_unit
// finds the final bumper point and car point for a turn-then-slide maneuver
// ----------------------------------------------------------------------------
// The unit takes one beat per clock while the output is not stalled. Each beat
// passes through four parallel cordic pipelines of CORDIC_STEPS + 2 stages,
// eleven geometry stages and a 35-stage one-bit-per-stage divider. A stall on
// the output freezes the whole pipeline and holds off the input; nothing is
// dropped. Registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while no beat is in flight, as the block does not
// enforce it.
module turn_then_offset_pose_solver_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tops_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tops_pkg::out_t   out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_data
);

    localparam int LC     = tops_pkg::CORDIC_LAT;
    localparam int ST_P1  = LC + 1;
    localparam int ST_P2  = LC + 2;
    localparam int ST_P3  = LC + 3;
    localparam int ST_P4  = LC + 4;
    localparam int ST_P5  = LC + 5;
    localparam int ST_P6  = LC + 6;
    localparam int ST_P7  = LC + 7;
    localparam int ST_P8  = ST_P7 + tops_pkg::DIV_LAT + 1;
    localparam int ST_P9  = ST_P8 + 1;
    localparam int ST_P10 = ST_P8 + 2;
    localparam int LAT    = ST_P8 + 3;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic        [15:0] dd;
        logic signed [31:0] c0;
        logic signed [31:0] s0;
        logic signed [31:0] co;
        logic signed [31:0] so;
        logic signed [31:0] cg;
        logic signed [31:0] sg;
        logic signed [31:0] sr;
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [63:0] pmx;
        logic signed [63:0] pmy;
        logic signed [63:0] prx;
        logic signed [63:0] pry;
        logic signed [34:0] mox;
        logic signed [34:0] moy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [63:0] sgdx;
        logic signed [63:0] cgdy;
        logic signed [63:0] dxc0;
        logic signed [63:0] dys0;
        logic signed [64:0] num;
        logic signed [34:0] tproj;
        logic signed [32:0] tt;
        logic signed [63:0] ptx;
        logic signed [63:0] pty;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               proj;
        logic               flag;
    } wk_t;

    logic [30:0] rad_reg;
    logic [30:0] off_reg;
    logic [14:0] tol_reg;

    wk_t  pl_reg  [1:LAT];
    wk_t  pl_next [1:LAT];
    logic [LAT:1] v_reg, v_next;
    logic         adv;

    logic [15:0] dd16;
    logic [15:0] oa16;
    logic [15:0] rel16;
    logic signed [31:0] c0_w, s0_w, co_w, so_w, cg_w, sg_w, cr_w, sr_w;
    logic signed [32:0] dq_w;
    logic               dclip_w;

    assign adv      = !(v_reg[LAT] && out_stall);
    assign in_stall = !adv;

    assign dd16  = in_data.goal_heading - in_data.bumper_heading;
    assign oa16  = in_data.car_heading + dd16;
    assign rel16 = in_data.goal_heading - in_data.car_heading;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= tops_pkg::TURN_RADIUS_RST;
            off_reg <= tops_pkg::BUMPER_OFFSET_RST;
            tol_reg <= tops_pkg::SINE_TOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tops_pkg::REG_TURN_RADIUS:   rad_reg <= cfg_data;
                tops_pkg::REG_BUMPER_OFFSET: off_reg <= cfg_data;
                tops_pkg::REG_SINE_TOL:      tol_reg <= cfg_data[14:0];
                default:                     ;
            endcase
        end
    end

    tops_cordic u_cordic_t0 (
        .clk   (clk),
        .en    (adv),
        .angle ({in_data.car_heading, 16'h0000}),
        .cos_q (c0_w),
        .sin_q (s0_w)
    );

    tops_cordic u_cordic_oa (
        .clk   (clk),
        .en    (adv),
        .angle ({oa16, 16'h0000}),
        .cos_q (co_w),
        .sin_q (so_w)
    );

    tops_cordic u_cordic_ga (
        .clk   (clk),
        .en    (adv),
        .angle ({in_data.goal_heading, 16'h0000}),
        .cos_q (cg_w),
        .sin_q (sg_w)
    );

    tops_cordic u_cordic_rel (
        .clk   (clk),
        .en    (adv),
        .angle ({rel16, 16'h0000}),
        .cos_q (cr_w),
        .sin_q (sr_w)
    );

    tops_div u_div (
        .clk  (clk),
        .en   (adv),
        .num  (pl_reg[ST_P7].num),
        .den  (pl_reg[ST_P7].sr),
        .quo  (dq_w),
        .clip (dclip_w)
    );

    always_comb
    begin
        tops_pkg::sat32_t sa;
        tops_pkg::sat32_t sb;
        tops_pkg::sat33_t st;
        logic [31:0] mag;
        v_next = {v_reg[LAT - 1:1], in_valid};

        pl_next[1]    = '0;
        pl_next[1].px = in_data.car_x;
        pl_next[1].py = in_data.car_y;
        pl_next[1].gx = in_data.goal_x;
        pl_next[1].gy = in_data.goal_y;
        pl_next[1].dd = dd16;
        for (int k = 2; k <= LAT; k++)
            pl_next[k] = pl_reg[k - 1];

        // trig results land, arc direction, near-parallel test
        pl_next[ST_P1].c0 = c0_w;
        pl_next[ST_P1].s0 = s0_w;
        pl_next[ST_P1].co = co_w;
        pl_next[ST_P1].so = so_w;
        pl_next[ST_P1].cg = cg_w;
        pl_next[ST_P1].sg = sg_w;
        pl_next[ST_P1].sr = sr_w;
        pl_next[ST_P1].ex = 33'(so_w) - 33'(s0_w);
        pl_next[ST_P1].ey = 33'(c0_w) - 33'(co_w);
        if (pl_reg[ST_P1 - 1].dd > tops_pkg::HALF_TURN)
        begin
            pl_next[ST_P1].ex = -(33'(so_w) - 33'(s0_w));
            pl_next[ST_P1].ey = -(33'(c0_w) - 33'(co_w));
        end
        pl_next[ST_P1].pmx = $signed({1'b0, off_reg}) * co_w;
        pl_next[ST_P1].pmy = $signed({1'b0, off_reg}) * so_w;
        mag = sr_w[31] ? 32'(-sr_w) : 32'(sr_w);
        pl_next[ST_P1].proj = (sr_w == 32'sd0) || (mag < {2'b00, tol_reg, 15'b0});

        // arc offset products
        pl_next[ST_P2].prx = $signed({1'b0, rad_reg}) * pl_reg[ST_P2 - 1].ex;
        pl_next[ST_P2].pry = $signed({1'b0, rad_reg}) * pl_reg[ST_P2 - 1].ey;
        pl_next[ST_P2].mox = tops_pkg::rnd_q30(pl_reg[ST_P2 - 1].pmx);
        pl_next[ST_P2].moy = tops_pkg::rnd_q30(pl_reg[ST_P2 - 1].pmy);

        // turn point
        sa = tops_pkg::sat32(36'(pl_reg[ST_P3 - 1].px)
                             + 36'(tops_pkg::rnd_q30(pl_reg[ST_P3 - 1].prx)));
        sb = tops_pkg::sat32(36'(pl_reg[ST_P3 - 1].py)
                             + 36'(tops_pkg::rnd_q30(pl_reg[ST_P3 - 1].pry)));
        if (pl_reg[ST_P3 - 1].dd == 16'h0000)
        begin
            pl_next[ST_P3].tx = pl_reg[ST_P3 - 1].px;
            pl_next[ST_P3].ty = pl_reg[ST_P3 - 1].py;
        end
        else
        begin
            pl_next[ST_P3].tx   = sa.val;
            pl_next[ST_P3].ty   = sb.val;
            pl_next[ST_P3].flag = pl_reg[ST_P3 - 1].flag | sa.clip | sb.clip;
        end

        // bumper start point
        sa = tops_pkg::sat32(36'(pl_reg[ST_P4 - 1].tx) + 36'(pl_reg[ST_P4 - 1].mox));
        sb = tops_pkg::sat32(36'(pl_reg[ST_P4 - 1].ty) + 36'(pl_reg[ST_P4 - 1].moy));
        pl_next[ST_P4].bx   = sa.val;
        pl_next[ST_P4].by   = sb.val;
        pl_next[ST_P4].flag = pl_reg[ST_P4 - 1].flag | sa.clip | sb.clip;

        pl_next[ST_P5].dx = 33'(pl_reg[ST_P5 - 1].gx) - 33'(pl_reg[ST_P5 - 1].bx);
        pl_next[ST_P5].dy = 33'(pl_reg[ST_P5 - 1].gy) - 33'(pl_reg[ST_P5 - 1].by);

        pl_next[ST_P6].sgdx = pl_reg[ST_P6 - 1].sg * pl_reg[ST_P6 - 1].dx;
        pl_next[ST_P6].cgdy = pl_reg[ST_P6 - 1].cg * pl_reg[ST_P6 - 1].dy;
        pl_next[ST_P6].dxc0 = pl_reg[ST_P6 - 1].dx * pl_reg[ST_P6 - 1].c0;
        pl_next[ST_P6].dys0 = pl_reg[ST_P6 - 1].dy * pl_reg[ST_P6 - 1].s0;

        pl_next[ST_P7].num   = 65'(pl_reg[ST_P7 - 1].sgdx) - 65'(pl_reg[ST_P7 - 1].cgdy);
        pl_next[ST_P7].tproj = tops_pkg::rnd_q30(65'(pl_reg[ST_P7 - 1].dxc0)
                                                 + 65'(pl_reg[ST_P7 - 1].dys0));

        // slide length
        st = tops_pkg::sat33(pl_reg[ST_P8 - 1].tproj);
        if (pl_reg[ST_P8 - 1].proj)
        begin
            pl_next[ST_P8].tt   = st.val;
            pl_next[ST_P8].flag = pl_reg[ST_P8 - 1].flag | st.clip;
        end
        else
        begin
            pl_next[ST_P8].tt   = dq_w;
            pl_next[ST_P8].flag = pl_reg[ST_P8 - 1].flag | dclip_w;
        end

        pl_next[ST_P9].ptx = pl_reg[ST_P9 - 1].tt * pl_reg[ST_P9 - 1].c0;
        pl_next[ST_P9].pty = pl_reg[ST_P9 - 1].tt * pl_reg[ST_P9 - 1].s0;

        // final bumper point
        sa = tops_pkg::sat32(36'(pl_reg[ST_P10 - 1].bx)
                             + 36'(tops_pkg::rnd_q30(pl_reg[ST_P10 - 1].ptx)));
        sb = tops_pkg::sat32(36'(pl_reg[ST_P10 - 1].by)
                             + 36'(tops_pkg::rnd_q30(pl_reg[ST_P10 - 1].pty)));
        pl_next[ST_P10].fx   = sa.val;
        pl_next[ST_P10].fy   = sb.val;
        pl_next[ST_P10].flag = pl_reg[ST_P10 - 1].flag | sa.clip | sb.clip;

        // final car point
        sa = tops_pkg::sat32(36'(pl_reg[LAT - 1].fx) - 36'(pl_reg[LAT - 1].mox));
        sb = tops_pkg::sat32(36'(pl_reg[LAT - 1].fy) - 36'(pl_reg[LAT - 1].moy));
        pl_next[LAT].rx   = sa.val;
        pl_next[LAT].ry   = sb.val;
        pl_next[LAT].flag = pl_reg[LAT - 1].flag | sa.clip | sb.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= LAT; k++)
                pl_reg[k] <= pl_next[k];
        end
    end

    assign out_valid                = v_reg[LAT];
    assign out_data.bumper_final_x  = pl_reg[LAT].fx;
    assign out_data.bumper_final_y  = pl_reg[LAT].fy;
    assign out_data.robot_final_x   = pl_reg[LAT].rx;
    assign out_data.robot_final_y   = pl_reg[LAT].ry;
    assign out_data.used_projection = pl_reg[LAT].proj;
    assign out_data.saturated       = pl_reg[LAT].flag;

endmodule

### rtl/core/tops_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tops_cordic
// pipelined rotation-mode cordic, one stage per iteration, gives cosine and
// sine in q2.30 of a 32-bit turn angle
// ----------------------------------------------------------------------------
module tops_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } cs_t;

    cs_t st_reg  [0:tops_pkg::CORDIC_STEPS];
    cs_t st_next [0:tops_pkg::CORDIC_STEPS];
    logic signed [31:0] cos_reg, cos_next;
    logic signed [31:0] sin_reg, sin_next;

    always_comb
    begin
        logic signed [33:0] z0;
        logic signed [33:0] xc;
        logic signed [33:0] yc;
        logic signed [33:0] at;
        z0 = 34'($signed(angle));
        st_next[0].x   = tops_pkg::CORDIC_START;
        st_next[0].y   = '0;
        st_next[0].z   = z0;
        st_next[0].neg = 1'b0;
        // fold into a quarter turn either side
        if (z0 > 34'sd1073741824)
        begin
            st_next[0].z   = z0 - 34'sd2147483648;
            st_next[0].neg = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            st_next[0].z   = z0 + 34'sd2147483648;
            st_next[0].neg = 1'b1;
        end
        for (int i = 0; i < tops_pkg::CORDIC_STEPS; i++)
        begin
            at = $signed({2'b00, tops_pkg::atan_turn(i)});
            st_next[i + 1].neg = st_reg[i].neg;
            if (!st_reg[i].z[33])
            begin
                st_next[i + 1].x = st_reg[i].x - (st_reg[i].y >>> i);
                st_next[i + 1].y = st_reg[i].y + (st_reg[i].x >>> i);
                st_next[i + 1].z = st_reg[i].z - at;
            end
            else
            begin
                st_next[i + 1].x = st_reg[i].x + (st_reg[i].y >>> i);
                st_next[i + 1].y = st_reg[i].y - (st_reg[i].x >>> i);
                st_next[i + 1].z = st_reg[i].z + at;
            end
        end
        xc = st_reg[tops_pkg::CORDIC_STEPS].x;
        yc = st_reg[tops_pkg::CORDIC_STEPS].y;
        if (xc > tops_pkg::ONE_Q30)
            xc = tops_pkg::ONE_Q30;
        if (xc < -tops_pkg::ONE_Q30)
            xc = -tops_pkg::ONE_Q30;
        if (yc > tops_pkg::ONE_Q30)
            yc = tops_pkg::ONE_Q30;
        if (yc < -tops_pkg::ONE_Q30)
            yc = -tops_pkg::ONE_Q30;
        if (st_reg[tops_pkg::CORDIC_STEPS].neg)
        begin
            xc = -xc;
            yc = -yc;
        end
        cos_next = xc[31:0];
        sin_next = yc[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= tops_pkg::CORDIC_STEPS; i++)
                st_reg[i] <= st_next[i];
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

### rtl/core/tops_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tops_div
// pipelined restoring divider, one quotient bit per stage, quotient truncated
// toward zero and saturated to [-2^32, 2^32 - 1]
// ----------------------------------------------------------------------------
module tops_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [64:0] num,
    input  logic signed [31:0] den,
    output logic signed [32:0] quo,
    output logic               clip
);

    typedef struct packed {
        logic [63:0] rem;
        logic [30:0] dmag;
        logic [32:0] q;
        logic        qneg;
        logic        ovf;
    } dv_t;

    dv_t dv_reg  [0:tops_pkg::DIV_QB];
    dv_t dv_next [0:tops_pkg::DIV_QB];
    logic signed [32:0] quo_reg, quo_next;
    logic               clip_reg, clip_next;

    always_comb
    begin
        logic [63:0] nmag;
        logic [31:0] dabs;
        logic [63:0] dsh;
        logic [32:0] qm;
        nmag = num[64] ? 64'(-num) : 64'(num);
        dabs = den[31] ? 32'(-den) : 32'(den);
        dv_next[0].rem  = nmag;
        dv_next[0].dmag = dabs[30:0];
        dv_next[0].q    = '0;
        dv_next[0].qneg = num[64] ^ den[31];
        dv_next[0].ovf  = nmag >= {dabs[30:0], 33'b0};
        for (int j = 0; j < tops_pkg::DIV_QB; j++)
        begin
            dv_next[j + 1] = dv_reg[j];
            dsh = 64'(dv_reg[j].dmag) << (tops_pkg::DIV_QB - 1 - j);
            if (dv_reg[j].rem >= dsh)
            begin
                dv_next[j + 1].rem = dv_reg[j].rem - dsh;
                dv_next[j + 1].q[tops_pkg::DIV_QB - 1 - j] = 1'b1;
            end
        end
        qm = dv_reg[tops_pkg::DIV_QB].q;
        clip_next = 1'b0;
        quo_next  = dv_reg[tops_pkg::DIV_QB].qneg ? 33'(-qm) : qm;
        if (dv_reg[tops_pkg::DIV_QB].qneg)
        begin
            if (dv_reg[tops_pkg::DIV_QB].ovf || qm > 33'h100000000)
            begin
                clip_next = 1'b1;
                quo_next  = 33'sh100000000;
            end
        end
        else if (dv_reg[tops_pkg::DIV_QB].ovf || qm > 33'h0FFFFFFFF)
        begin
            clip_next = 1'b1;
            quo_next  = 33'sh0FFFFFFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= tops_pkg::DIV_QB; j++)
                dv_reg[j] <= dv_next[j];
            quo_reg  <= quo_next;
            clip_reg <= clip_next;
        end
    end

    assign quo  = quo_reg;
    assign clip = clip_reg;

endmodule

### sim/tb_turn_then_offset_pose_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turn_then_offset_pose_solver_unit
// self-checking bench for the turn-then-offset pose solver: directed corner
// beats and random poses under several register settings, random idling on
// both channels and long output holds, every result compared field by
// field against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_turn_then_offset_pose_solver_unit;
    import tops_pkg::*;

    localparam logic [1:0] REG_NONE   = 2'd3;
    localparam int         DRAIN_WAIT = CORDIC_STEPS + 60;
    localparam int         STALL_MAX  = 3000;
    localparam int         LONG_HOLD  = 300;

    class pose_scoreboard;
        longint radius;
        longint offset;
        longint tol;
        out_t   pending[$];
        int     mismatches;
        int     matched;
        int     proj_seen;
        int     sat_seen;

        function new();
            radius = 65536;
            offset = 32768;
            tol    = 1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [30:0] v);
            case (idx)
                REG_TURN_RADIUS:   radius = v;
                REG_BUMPER_OFFSET: offset = v;
                REG_SINE_TOL:      tol    = v[14:0];
                default:           ;
            endcase
        endfunction

        function longint qmul(longint p, longint t);
            return (p * t + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function longint clip(longint v, longint lo, longint hi, inout bit flag);
            if (v < lo)
            begin
                flag = 1'b1;
                return lo;
            end
            if (v > hi)
            begin
                flag = 1'b1;
                return hi;
            end
            return v;
        endfunction

        function void rotate(logic [31:0] a, output longint c, output longint s);
            longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087,
                667544, 333772, 166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
            longint z, x, y, nx;
            bit flip;
            z    = longint'($signed(a));
            x    = 652032874;
            y    = 0;
            flip = 1'b0;
            if (z > (64'sd1 <<< 30))
            begin
                z    = z - (64'sd1 <<< 31);
                flip = 1'b1;
            end
            else if (z < -(64'sd1 <<< 30))
            begin
                z    = z + (64'sd1 <<< 31);
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_tab[i];
                end
                x = nx;
            end
            if (x > 1073741824) x = 1073741824;
            if (x < -1073741824) x = -1073741824;
            if (y > 1073741824) y = 1073741824;
            if (y < -1073741824) y = -1073741824;
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note(in_t b);
            logic [31:0] t0, ga, ba, dd, oa;
            longint c0, s0, co, so, cg, sg, cr, sr, ex, ey;
            longint tx, ty, bx, by, dx, dy, t, mag;
            longint lo32, hi32;
            bit flag;
            out_t r;
            lo32 = -64'sd2147483648;
            hi32 = 64'sd2147483647;
            flag = 1'b0;
            t0 = {b.car_heading, 16'h0};
            ga = {b.goal_heading, 16'h0};
            ba = {b.bumper_heading, 16'h0};
            dd = (ga - ba) & 32'hFFFF0000;
            oa = t0 + dd;
            rotate(t0, c0, s0);
            rotate(oa, co, so);
            rotate(ga, cg, sg);
            rotate(ga - t0, cr, sr);
            if (dd == 0)
            begin
                tx = b.car_x;
                ty = b.car_y;
            end
            else
            begin
                ex = so - s0;
                ey = c0 - co;
                if (dd > 32'h80000000)
                begin
                    ex = -ex;
                    ey = -ey;
                end
                tx = clip(longint'(b.car_x) + qmul(radius, ex), lo32, hi32, flag);
                ty = clip(longint'(b.car_y) + qmul(radius, ey), lo32, hi32, flag);
            end
            bx = clip(tx + qmul(offset, co), lo32, hi32, flag);
            by = clip(ty + qmul(offset, so), lo32, hi32, flag);
            dx = longint'(b.goal_x) - bx;
            dy = longint'(b.goal_y) - by;
            mag = sr < 0 ? -sr : sr;
            r.used_projection = (sr == 0 || mag < (tol <<< 15));
            if (r.used_projection)
                t = (dx * c0 + dy * s0 + (64'sd1 <<< 29)) >>> 30;
            else
                t = (sg * dx - cg * dy) / sr;
            t = clip(t, -64'sd4294967296, 64'sd4294967295, flag);
            bx = clip(bx + qmul(t, c0), lo32, hi32, flag);
            by = clip(by + qmul(t, s0), lo32, hi32, flag);
            r.bumper_final_x = bx[31:0];
            r.bumper_final_y = by[31:0];
            tx = clip(bx - qmul(offset, co), lo32, hi32, flag);
            ty = clip(by - qmul(offset, so), lo32, hi32, flag);
            r.robot_final_x = tx[31:0];
            r.robot_final_y = ty[31:0];
            r.saturated     = flag;
            pending.push_back(r);
        endfunction

        function void check(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.used_projection) proj_seen++;
            if (got.saturated) sat_seen++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d mismatch", matched + mismatches);
                    $display("  bumper x exp %0d got %0d, y exp %0d got %0d",
                             want.bumper_final_x, got.bumper_final_x,
                             want.bumper_final_y, got.bumper_final_y);
                    $display("  car x exp %0d got %0d, y exp %0d got %0d",
                             want.robot_final_x, got.robot_final_x,
                             want.robot_final_y, got.robot_final_y);
                    $display("  proj exp %0b got %0b, sat exp %0b got %0b",
                             want.used_projection, got.used_projection,
                             want.saturated, got.saturated);
                end
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    pose_scoreboard sb = new();
    int  quiet_cycles;
    int  beats_in;
    bit  send_idle;
    bit  recv_idle;
    bit  hold_req;

    turn_then_offset_pose_solver_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // accepted beats and watchdog
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note(in_data);
                beats_in++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                sb.check(out_data);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("timeout: no beat moved for %0d cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                w = recv_idle ? $urandom_range(0, 5) : 0;
                if (w > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_beat(in_t b);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] v);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1, 2:    return $urandom;
            default: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        endcase
    endfunction

    function automatic in_t pick_pose();
        in_t b;
        b.car_x          = pick_pos();
        b.car_y          = pick_pos();
        b.goal_x         = pick_pos();
        b.goal_y         = pick_pos();
        b.car_heading    = 16'($urandom);
        b.goal_heading   = 16'($urandom);
        b.bumper_heading = 16'($urandom);
        case ($urandom_range(0, 9))
            0: b.bumper_heading = b.goal_heading;
            1: b.bumper_heading = b.goal_heading + HALF_TURN;
            2, 3: b.goal_heading = 16'(b.car_heading
                                       + $signed($urandom_range(0, 400)) - 200);
            4: b.goal_heading = b.car_heading + HALF_TURN;
            default: ;
        endcase
        return b;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && $urandom_range(0, 1))
                hold_req = 1'b1;
            send_beat(pick_pose());
        end
    endtask

    initial
    begin
        in_t b;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_TURN_RADIUS;
        cfg_data  = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_req  = 1'b0;
        quiet_cycles = 0;
        beats_in  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at reset settings
        b = '0;
        send_beat(b);
        b.goal_heading = 16'sh4000;
        send_beat(b);
        b.goal_heading = -16'sh4000;
        send_beat(b);
        b.goal_heading = 16'sh8000;
        send_beat(b);
        b.goal_heading   = 16'sh0000;
        b.bumper_heading = 16'sh8000;
        send_beat(b);
        b.bumper_heading = 16'sh0000;
        b.car_heading    = 16'sh7FFF;
        b.goal_heading   = 16'sh8000;
        send_beat(b);
        b.goal_heading = 16'sh7FFE;
        send_beat(b);
        b.car_x  = 32'sh7FFFFFFF;
        b.car_y  = 32'sh7FFFFFFF;
        b.goal_x = 32'sh80000000;
        b.goal_y = 32'sh80000000;
        b.car_heading  = 16'sh2000;
        b.goal_heading = 16'sh2100;
        send_beat(b);
        b.car_x  = 32'sh80000000;
        b.car_y  = 32'sh80000000;
        b.goal_x = 32'sh7FFFFFFF;
        b.goal_y = 32'sh7FFFFFFF;
        b.bumper_heading = 16'sh7FFF;
        send_beat(b);
        b = '0;
        b.goal_x = 32'sh00010000;
        b.goal_y = 32'sh00050000;
        b.car_heading  = 16'sh4000;
        b.goal_heading = 16'sh0000;
        b.bumper_heading = 16'shC000;
        send_beat(b);
        b.goal_heading = 16'sh4003;
        send_beat(b);
        random_run(60);
        drain();

        // large radius, no offset, widest tolerance
        write_reg(REG_TURN_RADIUS, 31'h7FFFFFFF);
        write_reg(REG_BUMPER_OFFSET, 31'd0);
        write_reg(REG_SINE_TOL, 31'h7FFF);
        write_reg(REG_NONE, 31'h7FFFFFFF);
        b = '0;
        b.goal_heading = 16'sh4000;
        send_beat(b);
        b.goal_heading = 16'sh8000;
        send_beat(b);
        random_run(80);
        drain();

        // no radius, large offset, zero tolerance, no idling
        write_reg(REG_TURN_RADIUS, 31'd0);
        write_reg(REG_BUMPER_OFFSET, 31'h7FFFFFFF);
        write_reg(REG_SINE_TOL, 31'd0);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        random_run(80);
        drain();

        // mid values with pressure on the output
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_reg(REG_TURN_RADIUS, 31'h00030000);
        write_reg(REG_BUMPER_OFFSET, 31'h00008000);
        write_reg(REG_SINE_TOL, 31'd300);
        hold_req = 1'b1;
        send_idle = 1'b0;
        random_run(90);
        send_idle = 1'b1;
        drain();

        // random settings
        for (int p = 0; p < 2; p++)
        begin
            write_reg(REG_TURN_RADIUS, 31'($urandom_range(0, 32'h00100000)));
            write_reg(REG_BUMPER_OFFSET, 31'($urandom_range(0, 32'h00040000)));
            write_reg(REG_SINE_TOL, 31'($urandom_range(0, 2000)));
            random_run(50);
            drain();
        end

        $display("%0d pose beats checked, %0d matched; %0d used projection, %0d saturated",
                 beats_in, sb.matched, sb.proj_seen, sb.sat_seen);
        $display("four register settings plus two random ones, long output hold included");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
